@@ hdl/i2c_master_write_sequencer_defines.svh @@
`ifndef I2C_MASTER_WRITE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define I2CMWS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cmws check failed");

// Next-cycle implication
`define I2CMWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cmws check failed");

`endif

@@ hdl/i2cmws_pkg.sv @@
`default_nettype none
package i2cmws_pkg;

  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_SAMPLE = 3'd4;

  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_ACK     = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;
  localparam logic [1:0] STATUS_BUSY    = 2'd3;

  localparam int unsigned LimitW = 20;
  localparam logic [LimitW-1:0] LIMIT_RESET = 20'd100000;
  localparam logic REG_LIMIT = 1'b0;

  localparam logic [4:0] LEN_INIT  = 5'd11;
  localparam logic [4:0] LEN_START = 5'd4;
  localparam logic [4:0] LEN_STOP  = 5'd3;
  localparam logic [4:0] LEN_WRITE = 5'd26;
  localparam logic [4:0] LEN_BUSY  = 5'd1;
  localparam logic [4:0] LEN_END   = 5'd2;
  localparam logic [4:0] STEP_RELEASE = 5'd24;
  localparam logic [4:0] STEP_ACK_CLK = 5'd25;

  typedef enum logic [2:0] {
    KIND_INIT,
    KIND_START,
    KIND_STOP,
    KIND_WRITE,
    KIND_BUSY,
    KIND_END_ACK,
    KIND_END_TMO
  } kind_e;

  typedef enum logic [3:0] {
    ACT_SCL_OE,
    ACT_SDA_OE,
    ACT_SCL_LO,
    ACT_SCL_HI,
    ACT_SDA_LO,
    ACT_SDA_HI,
    ACT_SDA_BIT,
    ACT_SDA_REL,
    ACT_HOLD
  } action_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic scl_drive;
    logic sda_drive;
  } pins_t;

  function automatic action_e step_action(kind_e kind, logic [4:0] step, logic [1:0] phase);
    action_e act;
    act = ACT_HOLD;
    unique case (kind)
      KIND_INIT: begin
        unique case (step)
          5'd0:    act = ACT_SCL_OE;
          5'd1:    act = ACT_SDA_OE;
          5'd2:    act = ACT_SCL_HI;
          5'd3:    act = ACT_SDA_HI;
          5'd4:    act = ACT_SDA_HI;
          5'd5:    act = ACT_SCL_HI;
          5'd6:    act = ACT_SDA_LO;
          5'd7:    act = ACT_SCL_LO;
          5'd8:    act = ACT_SDA_LO;
          5'd9:    act = ACT_SCL_HI;
          5'd10:   act = ACT_SDA_HI;
          default: act = ACT_HOLD;
        endcase
      end
      KIND_START: begin
        unique case (step)
          5'd0:    act = ACT_SDA_HI;
          5'd1:    act = ACT_SCL_HI;
          5'd2:    act = ACT_SDA_LO;
          5'd3:    act = ACT_SCL_LO;
          default: act = ACT_HOLD;
        endcase
      end
      KIND_STOP: begin
        unique case (step)
          5'd0:    act = ACT_SDA_LO;
          5'd1:    act = ACT_SCL_HI;
          5'd2:    act = ACT_SDA_HI;
          default: act = ACT_HOLD;
        endcase
      end
      KIND_WRITE: begin
        priority if (step == STEP_RELEASE) act = ACT_SDA_REL;
        else if (step == STEP_ACK_CLK) act = ACT_SCL_HI;
        else if (phase == 2'd0) act = ACT_SDA_BIT;
        else if (phase == 2'd1) act = ACT_SCL_HI;
        else act = ACT_SCL_LO;
      end
      KIND_BUSY: act = ACT_HOLD;
      KIND_END_ACK, KIND_END_TMO: begin
        act = (step == 5'd0) ? ACT_SCL_LO : ACT_SDA_OE;
      end
      default: act = ACT_HOLD;
    endcase
    return act;
  endfunction

  function automatic logic [4:0] run_len(kind_e kind);
    logic [4:0] len;
    len = LEN_BUSY;
    unique case (kind)
      KIND_INIT:                  len = LEN_INIT;
      KIND_START:                 len = LEN_START;
      KIND_STOP:                  len = LEN_STOP;
      KIND_WRITE:                 len = LEN_WRITE;
      KIND_END_ACK, KIND_END_TMO: len = LEN_END;
      default:                    len = LEN_BUSY;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] run_status(kind_e kind);
    logic [1:0] st;
    st = STATUS_NONE;
    unique case (kind)
      KIND_BUSY:    st = STATUS_BUSY;
      KIND_END_ACK: st = STATUS_ACK;
      KIND_END_TMO: st = STATUS_TIMEOUT;
      default:      st = STATUS_NONE;
    endcase
    return st;
  endfunction

endpackage
`default_nettype wire

@@ hdl/i2c_master_write_sequencer.sv @@
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: opcode, data_byte, sda_in
// m_axis    out  tvalid/tready, tlast   tdata: scl/sda level, scl/sda drive, status
// apb       in   psel/penable, pready   ack_timeout_limit at byte address 0
//
// One result per clock from the back sequencer while m_axis is ready; each command gives
// a run of results ending in tlast. Samples that end nothing give no result.
// Commands queue ahead of the sequencer, so input is taken while results drain.
// Reset: all pins released and low, limit at 100000, no acknowledge wait.
// m_axis stall holds the sequencer; s_axis stalls only when the queue is full.
`default_nettype none
`include "i2c_master_write_sequencer_defines.svh"
module i2c_master_write_sequencer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [2:0] opcode, [10:3] data_byte, [11] sda_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] scl_level, [1] sda_level, [2] scl_drive,
                                           // [3] sda_drive, [5:4] status
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import i2cmws_pkg::*;

  logic [LimitW-1:0] limit_q;
  logic              s_accept;
  logic              push, pop, q_empty, q_full;
  cmd_t              push_cmd, head;
  pins_t             out_pins;
  logic [1:0]        out_status;

  // bits [1:0] of paddr are ignored; paddr[2] selects the register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIMIT) ? {{(32 - LimitW){1'b0}}, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LIMIT)) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  assign s_axis_tready = !q_full;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  i2cmws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (s_accept),
    .opcode_i    (s_axis_tdata[2:0]),
    .data_byte_i (s_axis_tdata[10:3]),
    .sda_in_i    (s_axis_tdata[11]),
    .limit_i     (limit_q),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  i2cmws_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  i2cmws_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_pins_o   (out_pins),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_status, out_pins.sda_drive, out_pins.scl_drive,
                         out_pins.sda_level, out_pins.scl_level};

  `I2CMWS_ASSERT_IMPL(a_push_not_full, push, !q_full)
  `I2CMWS_ASSERT_NEXT(a_push_fills, push, !q_empty)
  `I2CMWS_ASSERT_IMPL(a_busy_single, m_axis_tvalid && (out_status == STATUS_BUSY), m_axis_tlast)
  `I2CMWS_ASSERT_IMPL(a_end_redrives,
      m_axis_tvalid && m_axis_tlast && (out_status == STATUS_ACK || out_status == STATUS_TIMEOUT),
      out_pins.sda_drive && !out_pins.scl_level)

endmodule
`default_nettype wire

@@ hdl/i2cmws_front.sv @@
`default_nettype none
module i2cmws_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [2:0]                    opcode_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          sda_in_i,
  input  wire logic [i2cmws_pkg::LimitW-1:0] limit_i,
  output logic                               push_o,
  output i2cmws_pkg::cmd_t                   cmd_o
);
  import i2cmws_pkg::*;

  logic              waiting_q, waiting_d;
  logic [LimitW-1:0] count_q, count_d;
  logic [LimitW-1:0] count_inc;

  assign count_inc = count_q + LimitW'(1);

  // Acknowledge tracking lives here so later items classify without waiting on the pins
  always_comb begin
    waiting_d     = waiting_q;
    count_d       = count_q;
    push_o        = 1'b0;
    cmd_o.kind    = KIND_BUSY;
    cmd_o.data    = data_byte_i;
    if (accept_i) begin
      priority if (opcode_i > OP_SAMPLE) begin
        push_o = 1'b0;
      end else if (waiting_q) begin
        priority if (opcode_i != OP_SAMPLE) begin
          push_o     = 1'b1;
          cmd_o.kind = KIND_BUSY;
        end else if (!sda_in_i) begin
          push_o     = 1'b1;
          cmd_o.kind = KIND_END_ACK;
          waiting_d  = 1'b0;
        end else begin
          count_d = count_inc;
          if (count_inc >= limit_i) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_END_TMO;
            waiting_d  = 1'b0;
          end
        end
      end else begin
        unique case (opcode_i)
          OP_INIT: begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_INIT;
          end
          OP_START: begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_START;
          end
          OP_STOP: begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_STOP;
          end
          OP_WRITE: begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_WRITE;
            waiting_d  = 1'b1;
            count_d    = '0;
          end
          default: push_o = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
      count_q   <= '0;
    end else begin
      waiting_q <= waiting_d;
      count_q   <= count_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/i2cmws_queue.sv @@
`default_nettype none
module i2cmws_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire i2cmws_pkg::cmd_t push_cmd_i,
  input  wire logic             pop_i,
  output i2cmws_pkg::cmd_t      head_o,
  output logic                  empty_o,
  output logic                  full_o
);
  import i2cmws_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntFull);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    if (do_push && !do_pop) count_d = count_q + CntW'(1);
    else if (do_pop && !do_push) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule
`default_nettype wire

@@ hdl/i2cmws_back.sv @@
`default_nettype none
module i2cmws_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             head_valid_i,
  input  wire i2cmws_pkg::cmd_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output i2cmws_pkg::pins_t     out_pins_o,
  output logic [1:0]            out_status_o,
  output logic                  out_last_o
);
  import i2cmws_pkg::*;

  logic       out_valid_q, out_valid_d;
  pins_t      pins_q, pins_d;
  logic [1:0] status_q;
  logic       last_q;
  logic [4:0] step_q, step_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] bit_q, bit_d;
  logic       slot_free, fire, run_end;
  action_e    act;

  assign slot_free = !out_valid_q || out_ready_i;
  assign fire      = head_valid_i && slot_free;
  assign act       = step_action(head_i.kind, step_q, phase_q);
  assign run_end   = (step_q == run_len(head_i.kind) - 5'd1);
  assign pop_o     = fire && run_end;

  always_comb begin
    pins_d = pins_q;
    unique case (act)
      ACT_SCL_OE:  pins_d.scl_drive = 1'b1;
      ACT_SDA_OE:  pins_d.sda_drive = 1'b1;
      ACT_SCL_LO:  pins_d.scl_level = 1'b0;
      ACT_SCL_HI:  pins_d.scl_level = 1'b1;
      ACT_SDA_LO:  pins_d.sda_level = 1'b0;
      ACT_SDA_HI:  pins_d.sda_level = 1'b1;
      ACT_SDA_BIT: pins_d.sda_level = head_i.data[~bit_q]; // msb first
      ACT_SDA_REL: pins_d.sda_drive = 1'b0;
      default:     pins_d = pins_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    step_d      = step_q;
    phase_d     = phase_q;
    bit_d       = bit_q;
    if (slot_free) out_valid_d = fire;
    if (fire) begin
      if (run_end) begin
        step_d  = '0;
        phase_d = '0;
        bit_d   = '0;
      end else begin
        step_d  = step_q + 5'd1;
        phase_d = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
        bit_d   = (phase_q == 2'd2) ? bit_q + 3'd1 : bit_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pins_q      <= '0;
      step_q      <= '0;
      phase_q     <= '0;
      bit_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      if (fire) pins_q <= pins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= run_status(head_i.kind);
      last_q   <= run_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pins_o   = pins_q;
  assign out_status_o = status_q;
  assign out_last_o   = last_q;

endmodule
`default_nettype wire
